// ===== hw/rtl/ncs_pkg.sv =====
`default_nettype none

package ncs_pkg;

   localparam int MaxNest    = 255;
   localparam int DepthLimit = (MaxNest > 255) ? 255 : MaxNest;

   localparam logic [7:0] CharSlash   = 8'h2F;
   localparam logic [7:0] CharStar    = 8'h2A;
   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharNewline = 8'h0A;

   localparam logic [1:0] ClassCode    = 2'd0;
   localparam logic [1:0] ClassPending = 2'd1;
   localparam logic [1:0] ClassComment = 2'd2;

   localparam logic [1:0] KindNone   = 2'd0;
   localparam logic [1:0] KindLine   = 2'd1;
   localparam logic [1:0] KindBlock  = 2'd2;
   localparam logic [1:0] KindNested = 2'd3;

   typedef enum logic [7:0] {
      StIdle   = 8'b0000_0001,
      StPend   = 8'b0000_0010,
      StLine   = 8'b0000_0100,
      StBlock  = 8'b0000_1000,
      StBstar  = 8'b0001_0000,
      StNest   = 8'b0010_0000,
      StNslash = 8'b0100_0000,
      StNplus  = 8'b1000_0000
   } scan_state_type;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [1:0] byte_class;
      logic       slash_was_code;
      logic [1:0] kind;
      logic       comment_done;
      logic       error;
      logic [7:0] depth;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== hw/rtl/nested_comment_scanner.sv =====
// Scan state and nesting depth update as a byte moves from input to result register.
// Throughput: one byte per cycle unless rsp_stall holds a waiting result word.
// The input register and the result register let a new byte enter while a result waits.
// Reset is synchronous and active high: it empties both registers, returns the scanner
// to idle outside any comment with depth zero, and sets nested_enable to one.
`default_nettype none

module nested_comment_scanner (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire ncs_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output ncs_pkg::rsp_word_type      rsp_word,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire                        csr_wdata
);

   logic                       in_valid_ff;
   ncs_pkg::req_word_type      in_word_ff;
   logic                       rsp_valid_ff;
   ncs_pkg::rsp_word_type      rsp_word_ff;
   ncs_pkg::rsp_word_type      rsp_word_in;
   ncs_pkg::scan_state_type    state_ff;
   ncs_pkg::scan_state_type    state_in;
   logic [7:0]                 depth_ff;
   logic [7:0]                 depth_in;
   logic                       nested_enable_ff;
   logic                       out_free;
   logic                       move;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      logic [7:0] c;
      logic       fin;
      logic       reidle;
      c        = in_word_ff.byte_req;
      fin      = in_word_ff.last;
      reidle   = 1'b0;
      state_in = state_ff;
      depth_in = depth_ff;
      rsp_word_in = '0;
      rsp_word_in.byte_class = ncs_pkg::ClassCode;
      rsp_word_in.kind       = ncs_pkg::KindNone;

      case (state_ff)
         ncs_pkg::StIdle: begin
            reidle = 1'b1;
         end
         ncs_pkg::StPend: begin
            if (c == ncs_pkg::CharSlash) begin
               rsp_word_in.byte_class = ncs_pkg::ClassComment;
               rsp_word_in.kind       = ncs_pkg::KindLine;
               if (fin) begin
                  rsp_word_in.comment_done = 1'b1;
                  state_in = ncs_pkg::StIdle;
               end else begin
                  state_in = ncs_pkg::StLine;
               end
            end else if (c == ncs_pkg::CharStar) begin
               rsp_word_in.byte_class = ncs_pkg::ClassComment;
               rsp_word_in.kind       = ncs_pkg::KindBlock;
               state_in = ncs_pkg::StBlock;
            end else if (c == ncs_pkg::CharPlus && nested_enable_ff) begin
               rsp_word_in.byte_class = ncs_pkg::ClassComment;
               rsp_word_in.kind       = ncs_pkg::KindNested;
               depth_in = 8'd1;
               state_in = ncs_pkg::StNest;
            end else begin
               rsp_word_in.slash_was_code = 1'b1;
               reidle = 1'b1;
            end
         end
         ncs_pkg::StLine: begin
            rsp_word_in.kind = ncs_pkg::KindLine;
            if (c == ncs_pkg::CharNewline) begin
               rsp_word_in.byte_class   = ncs_pkg::ClassCode;
               rsp_word_in.comment_done = 1'b1;
               state_in = ncs_pkg::StIdle;
            end else begin
               rsp_word_in.byte_class = ncs_pkg::ClassComment;
               if (fin) begin
                  rsp_word_in.comment_done = 1'b1;
                  state_in = ncs_pkg::StIdle;
               end
            end
         end
         ncs_pkg::StBlock, ncs_pkg::StBstar: begin
            rsp_word_in.byte_class = ncs_pkg::ClassComment;
            rsp_word_in.kind       = ncs_pkg::KindBlock;
            if (state_ff == ncs_pkg::StBstar && c == ncs_pkg::CharSlash) begin
               rsp_word_in.comment_done = 1'b1;
               state_in = ncs_pkg::StIdle;
            end else if (c == ncs_pkg::CharStar) begin
               state_in = ncs_pkg::StBstar;
            end else begin
               state_in = ncs_pkg::StBlock;
            end
         end
         ncs_pkg::StNest, ncs_pkg::StNslash, ncs_pkg::StNplus: begin
            rsp_word_in.byte_class = ncs_pkg::ClassComment;
            rsp_word_in.kind       = ncs_pkg::KindNested;
            if (state_ff == ncs_pkg::StNslash && c == ncs_pkg::CharPlus) begin
               if (depth_ff >= 8'(ncs_pkg::DepthLimit)) begin
                  rsp_word_in.error        = 1'b1;
                  rsp_word_in.comment_done = 1'b1;
                  depth_in = 8'd0;
                  state_in = ncs_pkg::StIdle;
               end else begin
                  depth_in = depth_ff + 8'd1;
                  state_in = ncs_pkg::StNest;
               end
            end else if (state_ff == ncs_pkg::StNplus && c == ncs_pkg::CharSlash) begin
               if (depth_ff <= 8'd1) begin
                  depth_in = 8'd0;
                  rsp_word_in.comment_done = 1'b1;
                  state_in = ncs_pkg::StIdle;
               end else begin
                  depth_in = depth_ff - 8'd1;
                  state_in = ncs_pkg::StNest;
               end
            end else if (c == ncs_pkg::CharSlash) begin
               state_in = ncs_pkg::StNslash;
            end else if (c == ncs_pkg::CharPlus) begin
               state_in = ncs_pkg::StNplus;
            end else begin
               state_in = ncs_pkg::StNest;
            end
         end
         default: begin
            reidle = 1'b1;
         end
      endcase

      if (reidle) begin
         rsp_word_in.byte_class = ncs_pkg::ClassCode;
         rsp_word_in.kind       = ncs_pkg::KindNone;
         state_in = ncs_pkg::StIdle;
         if (c == ncs_pkg::CharSlash && !fin) begin
            rsp_word_in.byte_class = ncs_pkg::ClassPending;
            state_in = ncs_pkg::StPend;
         end
      end

      // A comment still open at the final byte is unterminated.
      if (fin && state_in != ncs_pkg::StIdle) begin
         rsp_word_in.error        = 1'b1;
         rsp_word_in.comment_done = 1'b1;
         depth_in = 8'd0;
         state_in = ncs_pkg::StIdle;
      end

      if (state_in != ncs_pkg::StNest && state_in != ncs_pkg::StNslash &&
          state_in != ncs_pkg::StNplus) begin
         depth_in = 8'd0;
      end

      rsp_word_in.depth = depth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         state_ff         <= ncs_pkg::StIdle;
         depth_ff         <= 8'd0;
         nested_enable_ff <= 1'b1;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
            depth_ff     <= depth_in;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            nested_enable_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
      if (move) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.error |-> rsp_word_ff.comment_done &&
      rsp_word_ff.depth == 8'd0 && state_ff == ncs_pkg::StIdle)
      else $error("error result without closing the comment");

   a_depth_in_nest: assert property (@(posedge clock) disable iff (reset)
      depth_ff != 8'd0 |-> state_ff == ncs_pkg::StNest ||
      state_ff == ncs_pkg::StNslash || state_ff == ncs_pkg::StNplus)
      else $error("nonzero depth outside a nesting comment");

   a_pending_state: assert property (@(posedge clock) disable iff (reset)
      move && rsp_word_in.byte_class == ncs_pkg::ClassPending |=>
      state_ff == ncs_pkg::StPend)
      else $error("pending slash without pending state");

   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      move && in_word_ff.last |=> state_ff == ncs_pkg::StIdle && depth_ff == 8'd0)
      else $error("scanner not idle after the final byte");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !move |=> $stable(state_ff) && $stable(depth_ff))
      else $error("scan state changed without a byte moving");

endmodule

`default_nettype wire

// ===== tb/nested_comment_scanner_tb.sv =====
`timescale 1ns / 1ps

module nested_comment_scanner_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ncs_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ncs_pkg::rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_wdata = 1'b0;

   nested_comment_scanner DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   ncs_pkg::scan_state_type scan_st = ncs_pkg::StIdle;
   logic [7:0] nest_lvl = 8'd0;
   logic nested_en = 1'b1;
   ncs_pkg::rsp_word_type predicted_words[$];

   int fail_count = 0;
   int bytes_sent = 0;
   int words_checked = 0;
   int input_stall_cycles = 0;
   int overflow_errors = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic ncs_pkg::rsp_word_type predict_scan(logic [7:0] ch, logic fin);
      ncs_pkg::rsp_word_type r;
      ncs_pkg::scan_state_type st;
      logic back_to_idle;
      r = '0;
      st = scan_st;
      back_to_idle = 1'b0;
      case (st)
         ncs_pkg::StPend: begin
            if (ch == ncs_pkg::CharSlash) begin
               r.byte_class = ncs_pkg::ClassComment;
               r.kind = ncs_pkg::KindLine;
               r.comment_done = fin;
               st = fin ? ncs_pkg::StIdle : ncs_pkg::StLine;
            end else if (ch == ncs_pkg::CharStar) begin
               r.byte_class = ncs_pkg::ClassComment;
               r.kind = ncs_pkg::KindBlock;
               st = ncs_pkg::StBlock;
            end else if (ch == ncs_pkg::CharPlus && nested_en) begin
               r.byte_class = ncs_pkg::ClassComment;
               r.kind = ncs_pkg::KindNested;
               nest_lvl = 8'd1;
               st = ncs_pkg::StNest;
            end else begin
               r.slash_was_code = 1'b1;
               back_to_idle = 1'b1;
            end
         end
         ncs_pkg::StLine: begin
            r.kind = ncs_pkg::KindLine;
            if (ch == ncs_pkg::CharNewline) begin
               r.byte_class = ncs_pkg::ClassCode;
               r.comment_done = 1'b1;
               st = ncs_pkg::StIdle;
            end else begin
               r.byte_class = ncs_pkg::ClassComment;
               if (fin) begin
                  r.comment_done = 1'b1;
                  st = ncs_pkg::StIdle;
               end
            end
         end
         ncs_pkg::StBlock, ncs_pkg::StBstar: begin
            r.byte_class = ncs_pkg::ClassComment;
            r.kind = ncs_pkg::KindBlock;
            if (st == ncs_pkg::StBstar && ch == ncs_pkg::CharSlash) begin
               r.comment_done = 1'b1;
               st = ncs_pkg::StIdle;
            end else begin
               st = (ch == ncs_pkg::CharStar) ? ncs_pkg::StBstar : ncs_pkg::StBlock;
            end
         end
         ncs_pkg::StNest, ncs_pkg::StNslash, ncs_pkg::StNplus: begin
            r.byte_class = ncs_pkg::ClassComment;
            r.kind = ncs_pkg::KindNested;
            if (st == ncs_pkg::StNslash && ch == ncs_pkg::CharPlus) begin
               if (nest_lvl >= ncs_pkg::DepthLimit) begin
                  r.error = 1'b1;
                  r.comment_done = 1'b1;
                  nest_lvl = 8'd0;
                  st = ncs_pkg::StIdle;
               end else begin
                  nest_lvl = nest_lvl + 8'd1;
                  st = ncs_pkg::StNest;
               end
            end else if (st == ncs_pkg::StNplus && ch == ncs_pkg::CharSlash) begin
               if (nest_lvl <= 8'd1) begin
                  nest_lvl = 8'd0;
                  r.comment_done = 1'b1;
                  st = ncs_pkg::StIdle;
               end else begin
                  nest_lvl = nest_lvl - 8'd1;
                  st = ncs_pkg::StNest;
               end
            end else if (ch == ncs_pkg::CharSlash) begin
               st = ncs_pkg::StNslash;
            end else if (ch == ncs_pkg::CharPlus) begin
               st = ncs_pkg::StNplus;
            end else begin
               st = ncs_pkg::StNest;
            end
         end
         default: back_to_idle = 1'b1;
      endcase
      if (back_to_idle) begin
         r.byte_class = ncs_pkg::ClassCode;
         r.kind = ncs_pkg::KindNone;
         st = ncs_pkg::StIdle;
         if (ch == ncs_pkg::CharSlash && !fin) begin
            r.byte_class = ncs_pkg::ClassPending;
            st = ncs_pkg::StPend;
         end
      end
      if (fin && st != ncs_pkg::StIdle) begin
         r.error = 1'b1;
         r.comment_done = 1'b1;
         nest_lvl = 8'd0;
         st = ncs_pkg::StIdle;
      end
      if (!(st inside {ncs_pkg::StNest, ncs_pkg::StNslash, ncs_pkg::StNplus}))
         nest_lvl = 8'd0;
      scan_st = st;
      r.depth = nest_lvl;
      return r;
   endfunction

   task automatic compare_word(ncs_pkg::rsp_word_type got);
      ncs_pkg::rsp_word_type want;
      if (predicted_words.size() == 0) begin
         $error("result word with no byte outstanding: %h", got);
         fail_count++;
      end else begin
         want = predicted_words.pop_front();
         words_checked++;
         if (got.byte_class !== want.byte_class) begin
            $error("byte_class: expected %0d, got %0d", want.byte_class, got.byte_class);
            fail_count++;
         end
         if (got.slash_was_code !== want.slash_was_code) begin
            $error("slash_was_code: expected %0d, got %0d",
               want.slash_was_code, got.slash_was_code);
            fail_count++;
         end
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count++;
         end
         if (got.comment_done !== want.comment_done) begin
            $error("comment_done: expected %0d, got %0d", want.comment_done, got.comment_done);
            fail_count++;
         end
         if (got.error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, got.error);
            fail_count++;
         end
         if (got.depth !== want.depth) begin
            $error("depth: expected %0d, got %0d", want.depth, got.depth);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      ncs_pkg::rsp_word_type w;
      if (!reset) begin
         if (csr_valid && csr_ready) nested_en = csr_wdata;
         if (req_valid && req_stall) input_stall_cycles++;
         if (req_valid && !req_stall) begin
            w = predict_scan(req_word.byte_req, req_word.last);
            if (w.error && w.kind == ncs_pkg::KindNested && w.depth == 8'd0 &&
                !req_word.last)
               overflow_errors++;
            predicted_words.push_back(w);
         end
         if (rsp_valid && !rsp_stall) compare_word(rsp_word);
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic send_byte(logic [7:0] ch, logic fin);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{byte_req: ch, last: fin};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(string s, logic fin_at_end);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_at_end && i == s.len() - 1);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_nested_enable(logic v);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_body_byte();
      case ($urandom_range(7))
         0: return ncs_pkg::CharStar;
         1: return ncs_pkg::CharPlus;
         2: return ncs_pkg::CharSlash;
         3: return ncs_pkg::CharNewline;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic test_directed_basics();
      req_idle_pct = 0;
      rsp_stall_pct = 28;
      send_byte(8'h00, 1'b0);
      send_byte(ncs_pkg::CharSlash, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(ncs_pkg::CharSlash, 1'b1);
      settle();
   endtask

   task automatic test_directed_comments();
      send_text("//\n", 1'b0);
      send_text("//", 1'b1);
      send_text("/***/", 1'b0);
      send_text("/*", 1'b1);
      send_text("/+/++/+/", 1'b0);
      settle();
   endtask

   task automatic test_enable_register();
      send_text("/+", 1'b0);
      write_nested_enable(1'b0);
      send_text("a+/", 1'b0);
      send_text("/+", 1'b0);
      write_nested_enable(1'b1);
   endtask

   task automatic test_depth_overflow();
      rsp_stall_pct = 0;
      repeat (ncs_pkg::DepthLimit) send_text("/+", 1'b0);
      send_text("+//+/+", 1'b0);
      settle();
   endtask

   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      settle();
      hold_cycles = 80;
      repeat (40) send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(8'h20, 1'b1);
      settle();
   endtask

   task automatic test_random_traffic(int n_bytes, int idle_pct, int stall_pct);
      int target;
      int lvl;
      target = bytes_sent + n_bytes;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (bytes_sent < target) begin
         case ($urandom_range(9))
            0, 1: repeat ($urandom_range(4, 1))
               send_byte(8'($urandom_range(255)), $urandom_range(99) < 2);
            2, 3: begin
               send_text("//", 1'b0);
               repeat ($urandom_range(6)) send_byte(pick_body_byte(), $urandom_range(99) < 2);
               send_byte(ncs_pkg::CharNewline, 1'b0);
            end
            4, 5: begin
               send_text("/*", 1'b0);
               repeat ($urandom_range(8)) send_byte(pick_body_byte(), $urandom_range(99) < 2);
               send_text("*/", 1'b0);
            end
            6, 7: begin
               send_text("/+", 1'b0);
               lvl = 1;
               repeat ($urandom_range(12)) begin
                  case ($urandom_range(5))
                     0: if (lvl < 4) begin
                        send_text("/+", 1'b0);
                        lvl++;
                     end
                     1: if (lvl > 1) begin
                        send_text("+/", 1'b0);
                        lvl--;
                     end
                     default: send_byte(pick_body_byte(), $urandom_range(99) < 2);
                  endcase
               end
               repeat (lvl) send_text("+/", 1'b0);
            end
            default: repeat ($urandom_range(6, 1))
               send_byte(pick_body_byte(), $urandom_range(99) < 3);
         endcase
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_directed_comments();
      test_enable_register();
      test_depth_overflow();
      test_backpressure();
      test_random_traffic(200, 0, 0);
      write_nested_enable(1'b0);
      test_random_traffic(200, 68, 0);
      write_nested_enable(1'b1);
      test_random_traffic(200, 0, 68);
      write_nested_enable(1'b0);
      test_random_traffic(80, 28, 28);
      write_nested_enable(1'b1);
      test_random_traffic(80, 28, 28);
      settle();
      repeat (8) @(posedge clock);
      $display("Scanned %0d bytes and checked %0d result words, with %0d depth overflows.",
         bytes_sent, words_checked, overflow_errors);
      $display("The input side was held off for %0d cycles under output backpressure.",
         input_stall_cycles);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
